// ===== hw/rtl/masr_pkg.sv =====
package masr_pkg;

  // Window of the temperature average
  localparam int AVG_DEPTH = 16;
  localparam int AVG_SHIFT = 4;

  // Slew limiter timing and step size
  localparam int RAMP_INTERVAL = 8;
  localparam int RAMP_STEP     = 1;

  // Field widths
  localparam int DATA_W = 16;
  localparam int PTR_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W  = DATA_W + $clog2(AVG_DEPTH);
  localparam int TICK_W = (RAMP_INTERVAL > 1) ? $clog2(RAMP_INTERVAL) : 1;
  localparam int STEP_W = DATA_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DATA_W-1:0] MAX16 = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT_LIMIT    = 2'd0,
    REG_MODULATION_OFFSET = 2'd1,
    REG_MODULATION_ENABLE = 2'd2,
    REG_RUN_ENABLE        = 2'd3
  } cfg_reg_t;

endpackage

// ===== hw/rtl/moving_average_setpoint_ramp_core.sv =====
// Moving average and setpoint ramp. Each input transaction carries one
// temperature reading and one modulation reading and produces exactly one
// result transaction: the working setpoint after this tick's slew step (or
// the reading itself when run_enable is 0), the modulated limit saturated to
// 0..65535, and the average over the last AVG_DEPTH readings. An item passes
// through the input register and then the result register; a new item is
// accepted every cycle while the result side takes one every cycle. The ring
// of readings sits in flip-flops that reset clears, so the block is ready
// once reset is released. The ramp step is taken on every RAMP_INTERVAL-th
// item, counted whether or not ramping is on. The user writes configuration
// registers only while no transaction is in flight; it is not enforced.
module moving_average_setpoint_ramp_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [masr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [masr_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // temp_sample, mod_sample
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata   // ramped_setpoint, modulated_limit,
                                                      // temp_average
);

  localparam int DW = masr_pkg::DATA_W;

  // Configuration registers
  logic [DW-1:0] limit_r;
  logic [DW-1:0] offset_r;
  logic          mod_en_r;
  logic          run_en_r;

  // Input stage
  logic          s1_valid_r;
  logic [DW-1:0] s1_temp_r;
  logic [DW-1:0] s1_mod_r;

  // Block state
  logic [DW-1:0]                  ring_r [masr_pkg::AVG_DEPTH];
  logic [masr_pkg::SUM_W-1:0]     sum_r;
  logic [masr_pkg::PTR_W-1:0]     ptr_r;
  logic [DW-1:0]                  sp_r;
  logic [masr_pkg::TICK_W-1:0]    tick_r;

  // Result stage
  logic          out_valid_r;
  logic [DW-1:0] res_sp_r;
  logic [DW-1:0] res_lim_r;
  logic [DW-1:0] res_avg_r;

  // Next values
  logic                           s1_adv;
  logic [masr_pkg::SUM_W-1:0]     sum_nxt;
  logic [masr_pkg::SUM_W-1:0]     avg_full;
  logic [DW-1:0]                  avg_nxt;
  logic [masr_pkg::PTR_W-1:0]     ptr_nxt;
  logic [masr_pkg::TICK_W-1:0]    tick_nxt;
  logic signed [DW+1:0]           lim_full;
  logic [DW-1:0]                  lim_nxt;
  logic [masr_pkg::STEP_W-1:0]    up_val;
  logic [masr_pkg::STEP_W-1:0]    dn_val;
  logic [DW-1:0]                  slew_val;
  logic [DW-1:0]                  sp_nxt;

  // Handshake: stage 1 moves when the result register is free or being taken
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_avg_r, res_lim_r, res_sp_r};

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= '0;
      offset_r <= '0;
      mod_en_r <= 1'b0;
      run_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (masr_pkg::cfg_reg_t'(cfg_index))
        masr_pkg::REG_SETPOINT_LIMIT:    limit_r  <= cfg_data[DW-1:0];
        masr_pkg::REG_MODULATION_OFFSET: offset_r <= cfg_data[DW-1:0];
        masr_pkg::REG_MODULATION_ENABLE: mod_en_r <= cfg_data[0];
        masr_pkg::REG_RUN_ENABLE:        run_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_temp_r <= in_tdata[DW-1:0];
      s1_mod_r  <= in_tdata[2*DW-1:DW];
    end
  end

  // Running sum: drop the oldest entry, add the new reading
  always_comb begin
    sum_nxt  = sum_r - masr_pkg::SUM_W'(ring_r[ptr_r])
                     + masr_pkg::SUM_W'(s1_temp_r);
    avg_full = sum_nxt >> masr_pkg::AVG_SHIFT;
    if (avg_full > masr_pkg::SUM_W'(masr_pkg::MAX16)) begin
      avg_nxt = masr_pkg::MAX16;
    end else begin
      avg_nxt = avg_full[DW-1:0];
    end
    if (ptr_r == masr_pkg::PTR_W'(masr_pkg::AVG_DEPTH - 1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  // Modulated limit, saturated to the 16-bit range
  always_comb begin
    lim_full = $signed({2'b00, limit_r});
    if (mod_en_r) begin
      lim_full = lim_full + $signed({2'b00, s1_mod_r}) - $signed({2'b00, offset_r});
    end
    if (lim_full > $signed({2'b00, masr_pkg::MAX16})) begin
      lim_nxt = masr_pkg::MAX16;
    end else if (lim_full < 0) begin
      lim_nxt = '0;
    end else begin
      lim_nxt = lim_full[DW-1:0];
    end
  end

  // Slew limiter: step toward the limit, land on it instead of passing it
  always_comb begin
    up_val = {1'b0, sp_r} + masr_pkg::STEP_W'(masr_pkg::RAMP_STEP);
    dn_val = {1'b0, sp_r} - masr_pkg::STEP_W'(masr_pkg::RAMP_STEP);
    if (sp_r <= limit_r) begin
      if (up_val >= {1'b0, limit_r}) begin
        slew_val = limit_r;
      end else begin
        slew_val = up_val[DW-1:0];
      end
    end else begin
      if (dn_val[DW] || (dn_val[DW-1:0] <= limit_r)) begin
        slew_val = limit_r;
      end else begin
        slew_val = dn_val[DW-1:0];
      end
    end

    if (!run_en_r) begin
      sp_nxt = s1_temp_r;
    end else if (tick_r == '0) begin
      sp_nxt = slew_val;
    end else begin
      sp_nxt = sp_r;
    end

    if (tick_r == masr_pkg::TICK_W'(masr_pkg::RAMP_INTERVAL - 1)) begin
      tick_nxt = '0;
    end else begin
      tick_nxt = tick_r + 1'b1;
    end
  end

  // Advance block state on each item that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < masr_pkg::AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      sum_r  <= '0;
      ptr_r  <= '0;
      sp_r   <= '0;
      tick_r <= '0;
    end else if (s1_adv) begin
      ring_r[ptr_r] <= s1_temp_r;
      sum_r         <= sum_nxt;
      ptr_r         <= ptr_nxt;
      sp_r          <= sp_nxt;
      tick_r        <= tick_nxt;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_sp_r  <= sp_nxt;
      res_lim_r <= lim_nxt;
      res_avg_r <= avg_nxt;
    end
  end

  // Tick counter stays inside its interval
  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r <= masr_pkg::TICK_W'(masr_pkg::RAMP_INTERVAL - 1))
    else $error("tick counter out of range");

  // Input is held off only when both stages are full and the result is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  // While ramping, the setpoint moves by at most one step per update
  a_slew_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && run_en_r && $past(run_en_r)) |->
      ((({1'b0, sp_r} >= {1'b0, $past(sp_r)}) ?
        ({1'b0, sp_r} - {1'b0, $past(sp_r)}) :
        ({1'b0, $past(sp_r)} - {1'b0, sp_r}))
       <= masr_pkg::STEP_W'(masr_pkg::RAMP_STEP)))
    else $error("setpoint moved by more than one ramp step");

  // State changes only with an item that produces a result
  a_state_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (ptr_r != $past(ptr_r))) |-> out_valid_r)
    else $error("ring pointer moved without a result");

endmodule

// ===== tb/tb_moving_average_setpoint_ramp_core.sv =====
`timescale 1ns / 100ps

module tb_moving_average_setpoint_ramp_core;
  import masr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 75;

  // one result transaction, last field in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0] avg;
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] sp;
  } reading_result_t;

  // Tracks ring, running sum, ramp and registers; holds the expected results
  class ramp_average_scoreboard;
    logic [DATA_W-1:0] history [AVG_DEPTH];
    logic [SUM_W-1:0]  win_sum;
    int unsigned       slot;
    int unsigned       tick;
    logic [DATA_W-1:0] working_sp;
    logic [DATA_W-1:0] limit_reg;
    logic [DATA_W-1:0] offset_reg;
    logic              mod_en;
    logic              run_en;
    reading_result_t   expected_results [$];
    int unsigned       errors;

    function new();
      foreach (history[i]) history[i] = '0;
      win_sum    = '0;
      slot       = 0;
      tick       = 0;
      working_sp = '0;
      limit_reg  = '0;
      offset_reg = '0;
      mod_en     = 1'b0;
      run_en     = 1'b0;
      errors     = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SETPOINT_LIMIT:    limit_reg  = val;
        REG_MODULATION_OFFSET: offset_reg = val;
        REG_MODULATION_ENABLE: mod_en     = val[0];
        REG_RUN_ENABLE:        run_en     = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Advance the model by one accepted reading and queue its result
    function void take_reading(logic [DATA_W-1:0] temp, logic [DATA_W-1:0] mod);
      int              lim;
      int              next_sp;
      logic [SUM_W-1:0] avg;
      reading_result_t r;
      // replace the oldest reading and keep the sum current
      win_sum = win_sum - history[slot] + temp;
      history[slot] = temp;
      slot = (slot + 1) % AVG_DEPTH;
      // limit plus corrected modulation, clamped to 16 bits
      lim = int'(limit_reg);
      if (mod_en) lim = lim + int'(mod) - int'(offset_reg);
      if (lim > int'(MAX16)) lim = int'(MAX16);
      else if (lim < 0) lim = 0;
      // slew toward the plain limit on the first tick of each interval
      if (run_en) begin
        if (tick == 0) begin
          if (working_sp <= limit_reg) begin
            next_sp = int'(working_sp) + RAMP_STEP;
            if (next_sp >= int'(limit_reg)) next_sp = int'(limit_reg);
          end else begin
            next_sp = int'(working_sp) - RAMP_STEP;
            if (next_sp <= int'(limit_reg)) next_sp = int'(limit_reg);
          end
          working_sp = next_sp[DATA_W-1:0];
        end
      end else begin
        working_sp = temp;
      end
      tick = (tick + 1) % RAMP_INTERVAL;
      avg = win_sum >> AVG_SHIFT;
      if (avg > SUM_W'(MAX16)) avg = SUM_W'(MAX16);
      r.sp  = working_sp;
      r.lim = lim[DATA_W-1:0];
      r.avg = avg[DATA_W-1:0];
      expected_results.push_back(r);
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic [47:0] data);
      reading_result_t got;
      reading_result_t exp_r;
      got = data;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.sp !== exp_r.sp) begin
        $display("%0t: ramped_setpoint expected %h got %h", $time, exp_r.sp, got.sp);
        errors++;
      end
      if (got.lim !== exp_r.lim) begin
        $display("%0t: modulated_limit expected %h got %h", $time, exp_r.lim, got.lim);
        errors++;
      end
      if (got.avg !== exp_r.avg) begin
        $display("%0t: temp_average expected %h got %h", $time, exp_r.avg, got.avg);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;   // temp_sample, mod_sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [47:0]           out_tdata;       // ramped_setpoint, modulated_limit, temp_average

  logic        hold_off = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  ramp_average_scoreboard sb = new();

  moving_average_setpoint_ramp_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Check each result transaction, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Count cycles without any transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
    $display("** moving_average_setpoint_ramp_core: FAILED **");
    $finish;
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write all four registers back to back
  task automatic configure(input logic [15:0] limit, input logic [15:0] offset,
                           input logic men, input logic ren);
    logic [CFG_DATA_W-1:0] vals [4];
    vals = '{limit, offset, 16'(men), 16'(ren)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_register(cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one reading after a random gap and wait for the transaction
  task automatic send_reading(input logic [15:0] temp, input logic [15:0] mod);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {mod, temp};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.take_reading(temp, mod);
  endtask

  // Drop valid and drain every outstanding result
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] lim_pick;
    int          near_sp;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturate the modulated limit high, fields at their extremes
    configure(16'hFFFF, 16'h0000, 1'b1, 1'b0);
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'h5555, 16'h8000);
    send_reading(16'hAAAA, 16'h0001);
    settle();

    // saturate it low
    configure(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    send_reading(16'hFFFF, 16'h0000);
    send_reading(16'h8000, 16'hFFFF);
    send_reading(16'h1234, 16'hAAAA);
    settle();

    // modulation off, setpoint tracks the reading
    configure(16'h1234, 16'hFFFF, 1'b0, 1'b0);
    send_reading(16'h0100, 16'h5555);
    settle();

    // ramp up one step and stop on the limit
    configure(16'h0101, 16'h0000, 1'b0, 1'b1);
    repeat (9) send_reading(pick_word(), pick_word());
    settle();

    // ramp down
    configure(16'h00FF, 16'h0000, 1'b0, 1'b1);
    repeat (9) send_reading(pick_word(), pick_word());
    settle();

    // random phases over all idling modes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      // a limit close to the setpoint lets the ramp reach it
      if ($urandom_range(1) == 1) begin
        near_sp = int'(sb.working_sp) + int'($urandom_range(12)) - 6;
        if (near_sp < 0) near_sp = 0;
        if (near_sp > int'(MAX16)) near_sp = int'(MAX16);
        lim_pick = near_sp[15:0];
      end else begin
        lim_pick = pick_word();
      end
      configure(lim_pick, pick_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      // hold the receiver off while the sender keeps pushing
      if (ph == 4) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      repeat (ITEMS_PER_PHASE) send_reading(pick_word(), pick_word());
      settle();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** moving_average_setpoint_ramp_core: PASSED **");
    end else begin
      $display("** moving_average_setpoint_ramp_core: FAILED **");
    end
    $finish;
  end

endmodule
